### rtl/assert_macros.svh
// Shared assertion macros for the palette match block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled at the rising clock edge, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// The expression must never be true.
`define ASSERT_NEVER(label, clk, rst, expr) \
   `ASSERT_CLK(label, clk, rst, !(expr))

`endif

### rtl/npm_pkg.sv
`default_nettype none

package npm_pkg;

   localparam int PALETTE_ENTRIES_DEF = 256;

   localparam int COLOR_W   = 8;
   localparam int RGB_W     = 3 * COLOR_W;
   localparam int SQ_W      = 2 * COLOR_W;
   localparam int DIST_W    = 18;
   localparam int POS_W     = 16;
   localparam int COUNT_W   = 9;
   localparam int SLOT_W    = 8;

   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET    = 9'd256;
   localparam logic [POS_W-1:0]   CLEAR_INTERVAL_RESET = 16'd100;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR_INTERVAL = 2'd1;

   typedef enum logic [REQ_TUSER_W-1:0] {
      ACT_LOAD  = 2'd0,
      ACT_MATCH = 2'd1,
      ACT_FRAME = 2'd2
   } action_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MOD    = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

endpackage

`default_nettype wire

### rtl/nearest_unused_palette_match.sv
// Load, start-of-frame and ignored transactions are absorbed without leaving ST_IDLE; req_tready stays high.
// A match raises rsp_tvalid after the position remainder, a scan of N entries and a drain,
// N being entry_count capped at PALETTE_ENTRIES, or PALETTE_ENTRIES on a clearing pixel;
// the scan reads one entry per cycle, and scan and drain are skipped when N is zero.
// req_tready returns together with rsp_tvalid; a stalled earlier result adds its wait.
// Reset sets entry_count to 256, clear_interval to 100 and the position to zero; the used
// mask is swept clear by the first match, which always falls on a clear.
`default_nettype none

module nearest_unused_palette_match #(
   parameter int PALETTE_ENTRIES = npm_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input transactions.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [npm_pkg::REQ_TDATA_W-1:0] req_tdata,  // entry_index, red, green, blue
   input  logic [npm_pkg::REQ_TUSER_W-1:0] req_tuser,  // action
   // Result transactions.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [npm_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // match_index, distance_squared
   output logic [npm_pkg::RSP_TUSER_W-1:0] rsp_tuser,  // found
   // Register writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [npm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [npm_pkg::CSR_DATA_W-1:0]  csr_data
);

   import npm_pkg::*;

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);
   localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

   // Request fields.
   action_type          req_action;
   logic [SLOT_W-1:0]   req_slot;
   rgb_type             req_rgb;
   logic                slot_ok;

   // Configuration.
   logic [COUNT_W-1:0]  entry_count_ff;
   logic [POS_W-1:0]    clear_interval_ff;
   logic [CNT_W-1:0]    count_eff;
   logic [POS_W-1:0]    interval_eff;

   // Control.
   state_type           state_ff, state_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   rgb_type             pix_ff, pix_in;
   logic                clear_ff, clear_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic [CNT_W-1:0]    scan_len_ff, scan_len_in;
   logic [CNT_W-1:0]    scan_len_next;
   logic [IDX_W-1:0]    scan_idx;

   // Scan pipeline tags.
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_range_ff, s1_range_in;
   logic [IDX_W-1:0]    s1_idx_ff, s1_idx_in;
   logic                s2_cand_ff, s2_cand_in;
   logic [IDX_W-1:0]    s2_idx_ff, s2_idx_in;

   // Best candidate so far.
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [DIST_W-1:0]   best_dist_ff, best_dist_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;

   // Unit connections.
   logic                mod_start;
   logic                mod_done;
   logic [POS_W-1:0]    mod_rem;
   logic                pal_we;
   rgb_type             pal_rd;
   logic                used_we;
   logic [IDX_W-1:0]    used_waddr;
   logic                used_wdata;
   logic                used_rd;
   logic [DIST_W-1:0]   entry_dist;
   logic                rsp_free;
   logic                req_fire;

   assign req_action    = action_type'(req_tuser);
   assign req_slot      = req_tdata[SLOT_W-1:0];
   assign req_rgb.red   = req_tdata[2*COLOR_W-1:COLOR_W];
   assign req_rgb.green = req_tdata[3*COLOR_W-1:2*COLOR_W];
   assign req_rgb.blue  = req_tdata[4*COLOR_W-1:3*COLOR_W];
   assign slot_ok       = 32'(req_slot) < PALETTE_ENTRIES;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (32'(entry_count_ff) > PALETTE_ENTRIES) begin
         count_eff = CNT_W'(PALETTE_ENTRIES);
      end else begin
         count_eff = CNT_W'(entry_count_ff);
      end
      interval_eff = (clear_interval_ff == '0) ? POS_W'(1) : clear_interval_ff;
   end

   // A clearing pixel sweeps the whole used mask, so entries beyond entry_count are
   // clean too if the count is raised later.
   assign scan_len_next = (mod_rem == '0) ? CNT_W'(PALETTE_ENTRIES) : count_eff;
   assign scan_idx      = scan_ff[IDX_W-1:0];
   assign rsp_free      = !rsp_valid_ff || rsp_tready;

   assign mod_start  = req_fire && (req_action == ACT_MATCH);
   assign pal_we     = req_fire && (req_action == ACT_LOAD) && slot_ok;
   assign used_we    = ((state_ff == ST_SCAN) && clear_ff)
                       || ((state_ff == ST_FINISH) && found_ff);
   assign used_waddr = (state_ff == ST_FINISH) ? best_idx_ff : scan_idx;
   assign used_wdata = (state_ff == ST_FINISH);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      pix_in       = pix_ff;
      clear_in     = clear_ff;
      scan_in      = scan_ff;
      scan_len_in  = scan_len_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_dist_in  = rsp_dist_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      s1_valid_in = (state_ff == ST_SCAN);
      s1_range_in = scan_ff < count_eff;
      s1_idx_in   = scan_idx;
      s2_cand_in  = s1_valid_ff && s1_range_ff && !(used_rd && !clear_ff);
      s2_idx_in   = s1_idx_ff;

      // Strict less-than keeps the lowest index among equal distances.
      if (s2_cand_ff && (!found_ff || (entry_dist < best_dist_ff))) begin
         found_in     = 1'b1;
         best_idx_in  = s2_idx_ff;
         best_dist_in = entry_dist;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_action)
                  ACT_MATCH: begin
                     pix_in   = req_rgb;
                     found_in = 1'b0;
                     state_in = ST_MOD;
                  end
                  ACT_FRAME: begin
                     pos_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               clear_in    = (mod_rem == '0);
               scan_len_in = scan_len_next;
               scan_in     = '0;
               state_in    = (scan_len_next == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff + 1'b1 == scan_len_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_cand_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_idx_in   = found_ff ? SLOT_W'(best_idx_ff) : '0;
               rsp_dist_in  = found_ff ? best_dist_ff : '0;
               pos_in       = pos_ff + 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         pos_ff            <= '0;
         entry_count_ff    <= ENTRY_COUNT_RESET;
         clear_interval_ff <= CLEAR_INTERVAL_RESET;
         s1_valid_ff       <= 1'b0;
         s2_cand_ff        <= 1'b0;
         found_ff          <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         s2_cand_ff   <= s2_cand_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ENTRY_COUNT) begin
               entry_count_ff <= csr_data[COUNT_W-1:0];
            end else if (csr_index == CSR_CLEAR_INTERVAL) begin
               clear_interval_ff <= csr_data[POS_W-1:0];
            end
         end
      end
      pix_ff       <= pix_in;
      clear_ff     <= clear_in;
      scan_ff      <= scan_in;
      scan_len_ff  <= scan_len_in;
      s1_range_ff  <= s1_range_in;
      s1_idx_ff    <= s1_idx_in;
      s2_idx_ff    <= s2_idx_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      rsp_found_ff <= rsp_found_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   npm_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (pos_ff),
      .divisor   (interval_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   npm_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (IDX_W'(req_slot)),
      .wr_data (req_rgb),
      .rd_addr (scan_idx),
      .rd_data (pal_rd)
   );

   npm_ram #(
      .WIDTH (1),
      .DEPTH (PALETTE_ENTRIES)
   ) u_used (
      .clock   (clock),
      .wr_en   (used_we),
      .wr_addr (used_waddr),
      .wr_data (used_wdata),
      .rd_addr (scan_idx),
      .rd_data (used_rd)
   );

   npm_dist_unit u_dist (
      .clock    (clock),
      .pixel    (pix_ff),
      .entry    (pal_rd),
      .distance (entry_dist)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - SLOT_W - DIST_W)'(0), rsp_dist_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_found_ff;

endmodule

`default_nettype wire

### rtl/npm_ram.sv
`default_nettype none

module npm_ram #(
   parameter int WIDTH = npm_pkg::RGB_W,
   parameter int DEPTH = npm_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/npm_mod_unit.sv
`default_nettype none

module npm_mod_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [npm_pkg::POS_W-1:0] dividend,
   input  logic [npm_pkg::POS_W-1:0] divisor,
   output logic                      done,
   output logic [npm_pkg::POS_W-1:0] remainder
);

   import npm_pkg::*;

   localparam int STEP_W = $clog2(POS_W + 1);

   logic [POS_W:0]     trial;
   logic [POS_W:0]     dsr_ext;
   logic [POS_W-1:0]   rem_ff, rem_in;
   logic [POS_W-1:0]   dvd_ff, dvd_in;
   logic [POS_W-1:0]   dsr_ff, dsr_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   // Restoring remainder: one dividend bit enters per cycle, most significant first.
   always_comb begin
      trial   = {rem_ff, dvd_ff[POS_W-1]};
      dsr_ext = {1'b0, dsr_ff};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= dsr_ext) begin
            rem_in = POS_W'(trial - dsr_ext);
         end else begin
            rem_in = trial[POS_W-1:0];
         end
         dvd_in  = dvd_ff << 1;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(POS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### rtl/npm_dist_unit.sv
`default_nettype none

module npm_dist_unit (
   input  logic                       clock,
   input  npm_pkg::rgb_type           pixel,
   input  npm_pkg::rgb_type           entry,
   output logic [npm_pkg::DIST_W-1:0] distance
);

   import npm_pkg::*;

   logic [COLOR_W-1:0] diff_r, diff_g, diff_b;
   logic [SQ_W-1:0]    sq_r_ff, sq_g_ff, sq_b_ff;

   always_comb begin
      diff_r = (pixel.red > entry.red) ? pixel.red - entry.red : entry.red - pixel.red;
      diff_g = (pixel.green > entry.green) ? pixel.green - entry.green
                                           : entry.green - pixel.green;
      diff_b = (pixel.blue > entry.blue) ? pixel.blue - entry.blue
                                         : entry.blue - pixel.blue;
   end

   always_ff @(posedge clock) begin
      sq_r_ff <= SQ_W'(diff_r) * SQ_W'(diff_r);
      sq_g_ff <= SQ_W'(diff_g) * SQ_W'(diff_g);
      sq_b_ff <= SQ_W'(diff_b) * SQ_W'(diff_b);
   end

   assign distance = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

endmodule

`default_nettype wire

### rtl/npm_checker.sv
`default_nettype none
`include "assert_macros.svh"

module npm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [npm_pkg::REQ_TUSER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [npm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [npm_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   import npm_pkg::*;

   // A result without a match carries index and distance of zero.
   `ASSERT_NEVER(a_not_found_zero, clock, reset, rsp_tvalid && !rsp_tuser[0] && (rsp_tdata != '0))

   // The distance never exceeds the largest possible squared RGB distance.
   `ASSERT_CLK(a_dist_range, clock, reset, rsp_tvalid |-> (rsp_tdata[25:8] <= 18'd195075))

   // A match transaction occupies the block, so the input side closes next cycle.
   `ASSERT_CLK(a_match_busy, clock, reset, (req_tvalid && req_tready && (req_tuser == ACT_MATCH)) |=> !req_tready)

   // A stalled result holds its payload.
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))

endmodule

bind nearest_unused_palette_match npm_checker u_npm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### tb/nearest_unused_palette_match_test.sv
`default_nettype none

module nearest_unused_palette_match_test;
   import npm_pkg::*;

   localparam logic [REQ_TUSER_W-1:0] ACT_IGNORED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED  = 2'd3;
   localparam int SETTLE_CYCLES = PALETTE_ENTRIES_DEF + 40;
   localparam int RANDOM_ITEMS  = 260;
   localparam int DRAIN_LIMIT   = 100000;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] index;
      logic [DIST_W-1:0] distance;
   } match_result_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [REQ_TUSER_W-1:0]  action;
      logic [SLOT_W-1:0]       slot;
      rgb_type                 color;
      logic [CSR_INDEX_W-1:0]  csr_index;
      logic [CSR_DATA_W-1:0]   csr_value;
      logic                    typed;
      match_result_type        result;
   } stim_row_type;

   localparam match_result_type UNCHECKED    = '0;
   localparam match_result_type NOT_FOUND    = '0;
   localparam match_result_type HIT_ZERO     = '{1'b1, 8'd0, 18'd0};
   localparam match_result_type HIT_FARTHEST = '{1'b1, 8'd0, 18'd195075};
   localparam rgb_type BLACK = '0;
   localparam rgb_type WHITE = '1;

   localparam int DIRECTED_ROWS = 27;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ROW_ITEM, ACT_LOAD,    8'd0,   BLACK, CSR_ENTRY_COUNT, 16'd0, 1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_LOAD,    8'd255, WHITE, CSR_ENTRY_COUNT, 16'd0, 1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_MATCH,   8'd0,   BLACK, CSR_ENTRY_COUNT, 16'd0, 1'b1, HIT_ZERO},
      '{ROW_ITEM, ACT_MATCH,   8'd0,   WHITE, CSR_ENTRY_COUNT, 16'd0, 1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_MATCH,   8'd0,   BLACK, CSR_ENTRY_COUNT, 16'd0, 1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_FRAME,   8'd255, WHITE, CSR_ENTRY_COUNT, 16'd0, 1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_MATCH,   8'd0, '{8'd128, 8'd64, 8'd32}, CSR_ENTRY_COUNT, 16'd0,
        1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_IGNORED, 8'd170, '{8'd85, 8'd170, 8'd85}, CSR_ENTRY_COUNT, 16'd0,
        1'b0, UNCHECKED},
      '{ROW_CSR,  ACT_LOAD,    8'd0,   BLACK, CSR_ENTRY_COUNT, 16'd0, 1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_MATCH,   8'd0, '{8'd10, 8'd20, 8'd30}, CSR_ENTRY_COUNT, 16'd0,
        1'b1, NOT_FOUND},
      '{ROW_CSR,  ACT_LOAD,    8'd0,   BLACK, CSR_ENTRY_COUNT, 16'd1, 1'b0, UNCHECKED},
      '{ROW_CSR,  ACT_LOAD,    8'd0,   BLACK, CSR_CLEAR_INTERVAL, 16'd65535, 1'b0,
        UNCHECKED},
      '{ROW_ITEM, ACT_FRAME,   8'd0,   BLACK, CSR_ENTRY_COUNT, 16'd0, 1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_MATCH,   8'd0,   WHITE, CSR_ENTRY_COUNT, 16'd0, 1'b1, HIT_FARTHEST},
      '{ROW_ITEM, ACT_MATCH,   8'd0,   BLACK, CSR_ENTRY_COUNT, 16'd0, 1'b1, NOT_FOUND},
      '{ROW_CSR,  ACT_LOAD,    8'd0,   BLACK, CSR_CLEAR_INTERVAL, 16'd0, 1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_MATCH,   8'd0,   BLACK, CSR_ENTRY_COUNT, 16'd0, 1'b1, HIT_ZERO},
      '{ROW_ITEM, ACT_MATCH,   8'd0,   BLACK, CSR_ENTRY_COUNT, 16'd0, 1'b1, HIT_ZERO},
      '{ROW_CSR,  ACT_LOAD,    8'd0,   BLACK, CSR_ENTRY_COUNT, 16'd511, 1'b0, UNCHECKED},
      '{ROW_CSR,  ACT_LOAD,    8'd0,   BLACK, CSR_CLEAR_INTERVAL, 16'd3, 1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_MATCH,   8'd0, '{8'd1, 8'd254, 8'd127}, CSR_ENTRY_COUNT, 16'd0,
        1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_MATCH,   8'd0, '{8'd255, 8'd0, 8'd255}, CSR_ENTRY_COUNT, 16'd0,
        1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_MATCH,   8'd0, '{8'd0, 8'd255, 8'd0}, CSR_ENTRY_COUNT, 16'd0,
        1'b0, UNCHECKED},
      '{ROW_CSR,  ACT_LOAD,    8'd0,   BLACK, CSR_UNUSED, 16'hFFFF, 1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_MATCH,   8'd0, '{8'd77, 8'd77, 8'd77}, CSR_ENTRY_COUNT, 16'd0,
        1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_LOAD,    8'd128, '{8'd255, 8'd0, 8'd255}, CSR_ENTRY_COUNT, 16'd0,
        1'b0, UNCHECKED},
      '{ROW_ITEM, ACT_MATCH,   8'd0, '{8'd255, 8'd0, 8'd255}, CSR_ENTRY_COUNT, 16'd0,
        1'b0, UNCHECKED}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // entry_index, red, green, blue
   logic [REQ_TUSER_W-1:0] req_tuser;   // action
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // match_index, distance_squared
   logic [RSP_TUSER_W-1:0] rsp_tuser;   // found
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Shadow copy of the block's state, kept by the predictor.
   rgb_type          palette_mem [PALETTE_ENTRIES_DEF];
   bit               used_bits [PALETTE_ENTRIES_DEF];
   logic [POS_W-1:0] pixel_pos;
   logic [COUNT_W-1:0] entry_count;
   logic [POS_W-1:0] clear_interval;

   match_result_type pending_matches [$];
   int               fault_count;
   bit               no_idle;
   bit               items_in_flight;

   nearest_unused_palette_match i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int draw_gap();
      if (no_idle) begin
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic logic [COLOR_W-1:0] pick_color();
      case ($urandom_range(0, 7))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   function automatic int color_sq(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
      int d;
      d = int'(a) - int'(b);
      return d * d;
   endfunction

   task automatic predict_item(input logic [REQ_TUSER_W-1:0] action,
                               input logic [REQ_TDATA_W-1:0] data,
                               output bit has_result, output match_result_type res);
      rgb_type px;
      rgb_type entry;
      int      limit;
      int      interval;
      int      best_dist;
      int      best_index;
      int      d;
      bit      hit;
      px.red     = data[15:8];
      px.green   = data[23:16];
      px.blue    = data[31:24];
      has_result = 1'b0;
      res        = '0;
      case (action)
         ACT_LOAD: begin
            palette_mem[data[7:0]] = px;
         end
         ACT_FRAME: begin
            pixel_pos = '0;
         end
         ACT_MATCH: begin
            interval = (clear_interval == 0) ? 1 : int'(clear_interval);
            limit = (int'(entry_count) > PALETTE_ENTRIES_DEF) ? PALETTE_ENTRIES_DEF
                                                              : int'(entry_count);
            if (int'(pixel_pos) % interval == 0) begin
               foreach (used_bits[i]) used_bits[i] = 1'b0;
            end
            hit        = 1'b0;
            best_dist  = 0;
            best_index = 0;
            for (int i = 0; i < limit; i++) begin
               if (!used_bits[i]) begin
                  entry = palette_mem[i];
                  d = color_sq(px.red, entry.red) + color_sq(px.green, entry.green)
                      + color_sq(px.blue, entry.blue);
                  // Strict compare keeps the lowest index on equal distances.
                  if (!hit || d < best_dist) begin
                     hit        = 1'b1;
                     best_dist  = d;
                     best_index = i;
                  end
               end
            end
            if (hit) begin
               used_bits[best_index] = 1'b1;
               res = '{1'b1, 8'(best_index), 18'(best_dist)};
            end
            pixel_pos  = pixel_pos + 1'b1;
            has_result = 1'b1;
         end
         default: begin
         end
      endcase
   endtask

   task automatic push_request(input logic [REQ_TUSER_W-1:0] action,
                               input logic [REQ_TDATA_W-1:0] data,
                               input logic typed, input match_result_type typed_result);
      int               gap;
      bit               has_result;
      match_result_type res;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = action;
      req_tdata  = data;
      do @(posedge clock); while (!req_tready);
      predict_item(action, data, has_result, res);
      if (typed) begin
         res = typed_result;
      end
      if (has_result) begin
         pending_matches = {pending_matches, res};
      end
      items_in_flight = 1'b1;
      @(negedge clock);
   endtask

   // Loads and frame starts leave no result behind, so a quiet period follows the
   // last result before any register write.
   task automatic settle();
      req_tvalid = 1'b0;
      if (items_in_flight) begin
         while (pending_matches.size() != 0) @(negedge clock);
         repeat (SETTLE_CYCLES) @(negedge clock);
         items_in_flight = 1'b0;
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_ENTRY_COUNT: begin
            entry_count = value[COUNT_W-1:0];
         end
         CSR_CLEAR_INTERVAL: begin
            clear_interval = value;
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin : result_sink
      int               gap;
      match_result_type got;
      match_result_type want;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = '{rsp_tuser[0], rsp_tdata[SLOT_W-1:0], rsp_tdata[SLOT_W+DIST_W-1:SLOT_W]};
         if (pending_matches.size() == 0) begin
            if (fault_count < 10) begin
               $display("unexpected result: found %0d index %0d dist %0d",
                        got.found, got.index, got.distance);
            end
            fault_count++;
         end else begin
            want = pending_matches.pop_front();
            if (got.found !== want.found || got.index !== want.index
                || got.distance !== want.distance) begin
               if (fault_count < 10) begin
                  $display("mismatch: found %0d/%0d index %0d/%0d dist %0d/%0d (exp/act)",
                           want.found, got.found, want.index, got.index,
                           want.distance, got.distance);
               end
               fault_count++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int                     sent;
      int                     pick;
      int                     waited;
      logic [REQ_TUSER_W-1:0] act;
      logic [REQ_TDATA_W-1:0] data;
      logic [CSR_DATA_W-1:0]  count_value;
      logic [CSR_DATA_W-1:0]  interval_value;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = ACT_LOAD;
      csr_valid       = 1'b0;
      csr_index       = CSR_ENTRY_COUNT;
      csr_data        = '0;
      no_idle         = 1'b0;
      fault_count     = 0;
      items_in_flight = 1'b0;
      entry_count     = ENTRY_COUNT_RESET;
      clear_interval  = CLEAR_INTERVAL_RESET;
      pixel_pos       = '0;
      foreach (used_bits[i]) used_bits[i] = 1'b0;
      foreach (palette_mem[i]) palette_mem[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Every slot is written first, so no match ever reads an unwritten entry.
      for (int s = 0; s < PALETTE_ENTRIES_DEF; s++) begin
         push_request(ACT_LOAD, {pick_color(), pick_color(), pick_color(), 8'(s)},
                      1'b0, UNCHECKED);
      end

      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].kind == ROW_CSR) begin
            settle();
            write_register(DIRECTED[r].csr_index, DIRECTED[r].csr_value);
         end else begin
            push_request(DIRECTED[r].action,
                         {DIRECTED[r].color.blue, DIRECTED[r].color.green,
                          DIRECTED[r].color.red, DIRECTED[r].slot},
                         DIRECTED[r].typed, DIRECTED[r].result);
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         case ($urandom_range(0, 7))
            0: count_value = 16'd0;
            1: count_value = 16'd1;
            2: count_value = 16'd256;
            3: count_value = 16'($urandom_range(257, 511));
            4: count_value = 16'($urandom_range(1, 256));
            default: count_value = 16'($urandom_range(2, 16));
         endcase
         case ($urandom_range(0, 7))
            0: interval_value = 16'd0;
            1: interval_value = 16'd65535;
            2: interval_value = 16'd1;
            3: interval_value = 16'($urandom_range(0, 65535));
            default: interval_value = 16'($urandom_range(2, 24));
         endcase
         write_register(CSR_ENTRY_COUNT, count_value);
         write_register(CSR_CLEAR_INTERVAL, interval_value);
         no_idle = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(20, 50)) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               act = ACT_LOAD;
            end else if (pick < 85) begin
               act = ACT_MATCH;
            end else if (pick < 94) begin
               act = ACT_FRAME;
            end else begin
               act = ACT_IGNORED;
            end
            data = {pick_color(), pick_color(), pick_color(), 8'($urandom_range(0, 255))};
            push_request(act, data, 1'b0, UNCHECKED);
            if (act != ACT_IGNORED) begin
               sent++;
            end
         end
      end

      req_tvalid = 1'b0;
      no_idle    = 1'b0;
      waited     = 0;
      while (pending_matches.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_matches.size() != 0) begin
         $display("%0d expected results never arrived", pending_matches.size());
         fault_count += pending_matches.size();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #30000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/npm_pkg.sv
rtl/npm_ram.sv
rtl/npm_mod_unit.sv
rtl/npm_dist_unit.sv
rtl/nearest_unused_palette_match.sv
rtl/npm_checker.sv
tb/nearest_unused_palette_match_test.sv
